// File: hw/rtl/light_adc_calibrate_and_level_defines.svh
// Assertion macros shared by the light level quantizer sources.
`ifndef LIGHT_ADC_CALIBRATE_AND_LEVEL_DEFINES_SVH
`define LIGHT_ADC_CALIBRATE_AND_LEVEL_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define LACL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold at every clock edge outside reset.
`define LACL_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// File: hw/rtl/lacl_pkg.sv
`default_nettype none

package lacl_pkg;

    // Fixed field widths.
    localparam int VALUE_BITS      = 16;
    localparam int GAIN_BITS       = 16;
    localparam int LEVEL_BITS      = 4;
    localparam int THRESHOLD_SLOTS = 10;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 64;

    // Defaults for the top-level parameters.
    localparam int NUM_LEVELS_DEF  = 10;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_CALIB_MODE  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GOLDEN_GAIN = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CALIB_GAIN  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THR_LOW     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THR_MID     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THR_HIGH    = 3'd5;

    // Control tag that travels with each word through the divider.
    typedef struct packed {
        logic valid;
        logic sat;
    } div_tag_t;

endpackage

`default_nettype wire

// File: hw/rtl/lacl_divider.sv
`default_nettype none
`include "light_adc_calibrate_and_level_defines.svh"

// Pipelined restoring divider, one quotient bit per stage.
// A word passes through the entry stage and then the quotient-bit stages in order.
module lacl_divider #(
    parameter int SAMPLE_BITS = lacl_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       in_valid,
    input  wire logic [SAMPLE_BITS+lacl_pkg::GAIN_BITS-1:0] dividend,
    input  wire logic [lacl_pkg::GAIN_BITS-1:0]             divisor,
    input  wire logic [SAMPLE_BITS-1:0]                     in_sample,
    output lacl_pkg::div_tag_t                              out_tag,
    output logic      [lacl_pkg::VALUE_BITS-1:0]            quotient,
    output logic      [SAMPLE_BITS-1:0]                     out_sample
);
    import lacl_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;

    div_tag_t               tag_reg [0:VALUE_BITS];
    logic [GAIN_BITS-1:0]   rem_reg [0:VALUE_BITS];
    logic [VALUE_BITS-1:0]  low_reg [0:VALUE_BITS];
    logic [VALUE_BITS-1:0]  q_reg   [0:VALUE_BITS];
    logic [SAMPLE_BITS-1:0] smp_reg [0:VALUE_BITS];

    logic [SAMPLE_BITS-1:0] dividend_hi;
    logic                   sat_next;

    // The quotient overflows 16 bits exactly when the upper part is not below the divisor.
    assign dividend_hi = dividend[PROD_BITS-1:VALUE_BITS];
    assign sat_next    = GAIN_BITS'(dividend_hi) >= divisor;

    // Entry stage: saturation check and loading of the partial remainder.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else
        begin
            tag_reg[0].valid <= in_valid;
            tag_reg[0].sat   <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= GAIN_BITS'(dividend_hi);
        low_reg[0] <= dividend[VALUE_BITS-1:0];
        q_reg[0]   <= '0;
        smp_reg[0] <= in_sample;
    end

    // One quotient bit per stage.
    for (genvar k = 1; k <= VALUE_BITS; k++)
    begin : g_stage
        logic [GAIN_BITS:0]   shifted;
        logic [GAIN_BITS:0]   diff;
        logic                 ge;

        assign shifted = {rem_reg[k-1], low_reg[k-1][VALUE_BITS-1]};
        assign diff    = shifted - {1'b0, divisor};
        assign ge      = shifted >= {1'b0, divisor};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k] <= '0;
            end
            else
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= ge ? diff[GAIN_BITS-1:0] : shifted[GAIN_BITS-1:0];
            low_reg[k] <= {low_reg[k-1][VALUE_BITS-2:0], 1'b0};
            q_reg[k]   <= {q_reg[k-1][VALUE_BITS-2:0], ge};
            smp_reg[k] <= smp_reg[k-1];
        end
    end

    assign out_tag    = tag_reg[VALUE_BITS];
    assign quotient   = q_reg[VALUE_BITS];
    assign out_sample = smp_reg[VALUE_BITS];

    // Each word moves one stage per cycle, so the last stage registers the valid bit of the stage before it.
    `LACL_ASSERT_ALWAYS(a_div_depth, clk, rst_n,
        out_tag.valid == $past(tag_reg[VALUE_BITS-1].valid), "divider lost or invented a word")
    // A finished unsaturated division leaves a remainder below the divisor.
    `LACL_ASSERT_IMPL(a_div_rem, clk, rst_n, out_tag.valid && !out_tag.sat,
        rem_reg[VALUE_BITS] < divisor, "divider remainder not reduced")
    // A word whose upper part reached the divisor is always flagged as saturated on entry.
    `LACL_ASSERT_IMPL(a_div_sat, clk, rst_n, tag_reg[0].valid && !tag_reg[0].sat,
        rem_reg[0] < divisor, "divider entry saturation flag wrong")

endmodule

`default_nettype wire

// File: hw/rtl/light_adc_calibrate_and_level.sv
// A word passes through the product register, the divider, the compare register and the result register.
// Throughput: one word per cycle; busy stays low, the pipeline takes a word every cycle.
// The 17-stage divider, an entry stage plus one stage per quotient bit, sets the latency.
// Reset clears the valid bits and loads calibrating_mode 0, both gains 1 and zero thresholds.
// The receiver cannot stall: each result is shown with done for one cycle.
`default_nettype none
`include "light_adc_calibrate_and_level_defines.svh"

module light_adc_calibrate_and_level #(
    parameter int NUM_LEVELS  = lacl_pkg::NUM_LEVELS_DEF,
    parameter int SAMPLE_BITS = lacl_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [lacl_pkg::VALUE_BITS-1:0]      adc_sample,
    input  wire logic                                 cfg_wen,
    input  wire logic [lacl_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [lacl_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output logic                                      done,
    output logic      [lacl_pkg::VALUE_BITS-1:0]      scaled_value,
    output logic      [lacl_pkg::LEVEL_BITS-1:0]      light_level
);
    import lacl_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;
    localparam int THR_BITS  = THRESHOLD_SLOTS * VALUE_BITS;

    // Configuration registers.
    logic                     calib_mode_reg;
    logic [GAIN_BITS-1:0]     golden_gain_reg;
    logic [GAIN_BITS-1:0]     calib_gain_reg;
    logic [63:0]              thr_low_reg;
    logic [63:0]              thr_mid_reg;
    logic [31:0]              thr_high_reg;

    // Pipeline registers.
    logic                     prod_valid_reg;
    logic [PROD_BITS-1:0]     prod_reg;
    logic [SAMPLE_BITS-1:0]   prod_smp_reg;
    logic [PROD_BITS-1:0]     prod_next;

    div_tag_t                 div_tag;
    logic [VALUE_BITS-1:0]    div_quot;
    logic [SAMPLE_BITS-1:0]   div_smp;

    logic                     cmp_valid_reg;
    logic [VALUE_BITS-1:0]    cmp_value_reg;
    logic [NUM_LEVELS-1:0]    cmp_hit_reg;
    logic                     cmp_fallback_reg;
    logic [VALUE_BITS-1:0]    value_next;
    logic [NUM_LEVELS-1:0]    hit_next;
    logic                     fallback_next;

    logic                     done_reg;
    logic [VALUE_BITS-1:0]    scaled_reg;
    logic [LEVEL_BITS-1:0]    level_reg;
    logic [LEVEL_BITS-1:0]    level_next;

    logic [THR_BITS-1:0]      thr_all;

    assign busy = 1'b0;

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_mode_reg  <= 1'b0;
            golden_gain_reg <= GAIN_BITS'(1);
            calib_gain_reg  <= GAIN_BITS'(1);
            thr_low_reg     <= '0;
            thr_mid_reg     <= '0;
            thr_high_reg    <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_CALIB_MODE:  calib_mode_reg  <= cfg_data[0];
                CFG_GOLDEN_GAIN: golden_gain_reg <= cfg_data[GAIN_BITS-1:0];
                CFG_CALIB_GAIN:  calib_gain_reg  <= cfg_data[GAIN_BITS-1:0];
                CFG_THR_LOW:     thr_low_reg     <= cfg_data;
                CFG_THR_MID:     thr_mid_reg     <= cfg_data;
                CFG_THR_HIGH:    thr_high_reg    <= cfg_data[31:0];
                default:         ;
            endcase
        end
    end

    // Stage 1: sample times golden gain.
    assign prod_next = PROD_BITS'(adc_sample[SAMPLE_BITS-1:0]) * PROD_BITS'(golden_gain_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        prod_smp_reg <= adc_sample[SAMPLE_BITS-1:0];
    end

    // Stages 2 to 18: divide by the calibrated gain.
    lacl_divider #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (prod_valid_reg),
        .dividend   (prod_reg),
        .divisor    (calib_gain_reg),
        .in_sample  (prod_smp_reg),
        .out_tag    (div_tag),
        .quotient   (div_quot),
        .out_sample (div_smp)
    );

    // Stage 19: pick the value and compare it against every threshold.
    assign thr_all = {thr_high_reg, thr_mid_reg, thr_low_reg};

    always_comb
    begin
        logic all_zero;
        all_zero = 1'b1;
        if (calib_mode_reg)
        begin
            value_next = VALUE_BITS'(div_smp);
        end
        else if (div_tag.sat)
        begin
            value_next = VALUE_MAX;
        end
        else
        begin
            value_next = div_quot;
        end
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            hit_next[i] = (thr_all[i*VALUE_BITS +: VALUE_BITS] != '0)
                       && (value_next <= thr_all[i*VALUE_BITS +: VALUE_BITS]);
            if (thr_all[i*VALUE_BITS +: VALUE_BITS] != '0)
            begin
                all_zero = 1'b0;
            end
        end
        fallback_next = all_zero && (value_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= div_tag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_value_reg    <= value_next;
        cmp_hit_reg      <= hit_next;
        cmp_fallback_reg <= fallback_next;
    end

    // Stage 20: first matching threshold wins.
    always_comb
    begin
        level_next = cmp_fallback_reg ? LEVEL_BITS'(NUM_LEVELS - 1) : '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (cmp_hit_reg[i])
            begin
                level_next = LEVEL_BITS'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        scaled_reg <= cmp_value_reg;
        level_reg  <= level_next;
    end

    assign done         = done_reg;
    assign scaled_value = scaled_reg;
    assign light_level  = level_reg;

    // The level never leaves the configured range.
    `LACL_ASSERT_IMPL(a_level_range, clk, rst_n, done,
        light_level <= LEVEL_BITS'(NUM_LEVELS - 1), "light level out of range")
    // A nonzero level needs a matching threshold or the all-cleared fallback behind it.
    `LACL_ASSERT_IMPL(a_level_hit, clk, rst_n,
        cmp_valid_reg && (cmp_hit_reg == '0) && !cmp_fallback_reg,
        level_next == '0, "level without matching threshold")
    // Each result word follows a compared word through the result register.
    `LACL_ASSERT_ALWAYS(a_done_follow, clk, rst_n,
        done == $past(cmp_valid_reg), "result strobe out of step")

endmodule

`default_nettype wire

// File: tb/light_adc_calibrate_and_level_test.sv
`timescale 1ns / 1ps

module light_adc_calibrate_and_level_test;
    import lacl_pkg::*;

    localparam int LEVELS          = NUM_LEVELS_DEF;
    localparam int THR_BITS        = THRESHOLD_SLOTS * VALUE_BITS;
    localparam int PIPE_CYCLES     = 20;
    localparam int SETTLE_CYCLES   = 2 * PIPE_CYCLES + 8;
    localparam int RANDOM_PHASES   = 12;
    localparam int WORDS_PER_PHASE = 86;
    localparam int REPORT_LINES    = 40;
    localparam longint LIMIT_NS    = 5_000_000;

    // Register indexes that map to nothing; writes there must be dropped.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 3'd7;

    typedef enum bit {ENTRY_SAMPLE, ENTRY_WRITE} entry_kind_t;

    typedef struct {
        entry_kind_t              kind;
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] data;
        logic [VALUE_BITS-1:0]    sample;
        int unsigned              hold_off;
    } bus_entry_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [LEVEL_BITS-1:0] level;
    } level_reading_t;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     start      = 1'b0;
    logic [VALUE_BITS-1:0]    adc_sample = '0;
    logic                     cfg_wen    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data   = '0;
    logic                     busy;
    logic                     done;
    logic [VALUE_BITS-1:0]    scaled_value;
    logic [LEVEL_BITS-1:0]    light_level;

    // Predictor copy of the configuration registers, at their reset values.
    logic                     lvl_mode     = 1'b0;
    logic [GAIN_BITS-1:0]     lvl_gold     = 16'd1;
    logic [GAIN_BITS-1:0]     lvl_cal      = 16'd1;
    logic [63:0]              lvl_thr_low  = '0;
    logic [63:0]              lvl_thr_mid  = '0;
    logic [31:0]              lvl_thr_high = '0;

    // Setting the stimulus planner has queued last, used to aim samples.
    logic                     plan_mode = 1'b0;
    logic [GAIN_BITS-1:0]     plan_gold = 16'd1;
    logic [GAIN_BITS-1:0]     plan_cal  = 16'd1;
    logic [THR_BITS-1:0]      plan_thr  = '0;

    bus_entry_t               pending[$];
    level_reading_t           readings_due[$];
    int                       mismatches = 0;
    logic                     word_taken = 1'b0;
    int unsigned              hold_left  = 0;

    light_adc_calibrate_and_level DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .adc_sample   (adc_sample),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .scaled_value (scaled_value),
        .light_level  (light_level)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        if (mismatches < REPORT_LINES)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Scale the sample by the gain ratio, then find its brightness level.
    function automatic level_reading_t predict_reading(input logic [VALUE_BITS-1:0] raw);
        level_reading_t        r;
        logic [31:0]           product;
        logic [31:0]           quotient;
        logic [THR_BITS-1:0]   thr;
        logic [VALUE_BITS-1:0] slot;
        bit                    any_set;
        bit                    found;
        if (lvl_mode)
            r.value = raw;
        else if (lvl_cal == 0)
            r.value = VALUE_MAX;
        else
        begin
            product  = {16'b0, raw} * {16'b0, lvl_gold};
            quotient = product / {16'b0, lvl_cal};
            r.value  = (quotient > {16'b0, VALUE_MAX}) ? VALUE_MAX : quotient[VALUE_BITS-1:0];
        end
        thr     = {lvl_thr_high, lvl_thr_mid, lvl_thr_low};
        any_set = 1'b0;
        found   = 1'b0;
        r.level = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            slot = thr[i*VALUE_BITS +: VALUE_BITS];
            if (slot != 0)
            begin
                any_set = 1'b1;
                if (!found && r.value <= slot)
                begin
                    found   = 1'b1;
                    r.level = i[LEVEL_BITS-1:0];
                end
            end
        end
        // A zero value with every threshold cleared reads as the top level.
        if (!found && r.value == 0 && !any_set)
            r.level = LEVEL_BITS'(LEVELS - 1);
        return r;
    endfunction

    task automatic apply_register_write(input logic [CFG_IDX_BITS-1:0]  index,
                                        input logic [CFG_DATA_BITS-1:0] data);
        case (index)
            CFG_CALIB_MODE:  lvl_mode     = data[0];
            CFG_GOLDEN_GAIN: lvl_gold     = data[GAIN_BITS-1:0];
            CFG_CALIB_GAIN:  lvl_cal      = data[GAIN_BITS-1:0];
            CFG_THR_LOW:     lvl_thr_low  = data;
            CFG_THR_MID:     lvl_thr_mid  = data;
            CFG_THR_HIGH:    lvl_thr_high = data[31:0];
            default:         ;
        endcase
    endtask

    task automatic queue_write(input logic [CFG_IDX_BITS-1:0]  index,
                               input logic [CFG_DATA_BITS-1:0] data);
        bus_entry_t e;
        e.kind     = ENTRY_WRITE;
        e.index    = index;
        e.data     = data;
        e.sample   = '0;
        e.hold_off = 0;
        pending.push_back(e);
    endtask

    task automatic queue_sample(input logic [VALUE_BITS-1:0] sample, input int unsigned hold_off);
        bus_entry_t e;
        e.kind     = ENTRY_SAMPLE;
        e.index    = '0;
        e.data     = '0;
        e.sample   = sample;
        e.hold_off = hold_off;
        pending.push_back(e);
    endtask

    // Queue writes of every register; unused upper bits carry random junk.
    task automatic program_setting(input logic                 mode,
                                   input logic [GAIN_BITS-1:0] gold,
                                   input logic [GAIN_BITS-1:0] cal,
                                   input logic [THR_BITS-1:0]  thr);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        queue_write(CFG_CALIB_MODE, {junk[63:1], mode});
        junk = {$urandom, $urandom};
        queue_write(CFG_GOLDEN_GAIN, {junk[63:16], gold});
        junk = {$urandom, $urandom};
        queue_write(CFG_CALIB_GAIN, {junk[63:16], cal});
        queue_write(CFG_THR_LOW, thr[63:0]);
        queue_write(CFG_THR_MID, thr[127:64]);
        junk = {$urandom, $urandom};
        queue_write(CFG_THR_HIGH, {junk[63:32], thr[159:128]});
        plan_mode = mode;
        plan_gold = gold;
        plan_cal  = cal;
        plan_thr  = thr;
    endtask

    function automatic logic [GAIN_BITS-1:0] pick_gain();
        case ($urandom_range(0, 19))
            0, 1:    return 16'd1;
            2, 3:    return 16'hFFFF;
            4, 5, 6: return GAIN_BITS'($urandom_range(1, 16));
            19:      return 16'd0;
            default: return GAIN_BITS'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [THR_BITS-1:0] pick_thresholds();
        logic [THR_BITS-1:0] thr;
        int                  style;
        int                  acc;
        int                  lone;
        thr   = '0;
        style = $urandom_range(0, 5);
        acc   = $urandom_range(0, 2000);
        lone  = $urandom_range(0, THRESHOLD_SLOTS - 1);
        for (int i = 0; i < THRESHOLD_SLOTS; i++)
        begin
            acc = acc + $urandom_range(0, 8000);
            if (acc > 65535)
                acc = 65535;
            case (style)
                0, 1:    thr[i*VALUE_BITS +: VALUE_BITS] = acc[15:0];
                2:       thr[i*VALUE_BITS +: VALUE_BITS] = 16'($urandom);
                3:       thr[i*VALUE_BITS +: VALUE_BITS] =
                             ($urandom_range(0, 2) == 0) ? 16'd0 : acc[15:0];
                4:       thr[i*VALUE_BITS +: VALUE_BITS] = 16'd0;
                default: thr[i*VALUE_BITS +: VALUE_BITS] =
                             (i == lone) ? 16'($urandom) : 16'd0;
            endcase
        end
        return thr;
    endfunction

    // Aim some samples at the edges of thresholds under the planned gain ratio, the rest at random values and extremes.
    function automatic logic [VALUE_BITS-1:0] pick_sample();
        longint target;
        int     slot;
        int     offset;
        case ($urandom_range(0, 7))
            0, 1, 2: target = longint'($urandom_range(0, 65535));
            3:       target = longint'($urandom_range(0, 15));
            4:       target = longint'($urandom_range(65520, 65535));
            default:
            begin
                slot   = $urandom_range(0, THRESHOLD_SLOTS - 1);
                target = longint'(plan_thr[slot*VALUE_BITS +: VALUE_BITS]);
                if (!plan_mode && plan_gold != 0)
                    target = (target * plan_cal) / plan_gold;
                offset = $urandom_range(0, 2);
                target = target + offset - 1;
                if (target < 0 || target > 65535)
                    target = longint'($urandom_range(0, 65535));
            end
        endcase
        return target[VALUE_BITS-1:0];
    endfunction

    // Driver: present one word at a time; register writes wait for an idle pipeline.
    always @(negedge clk)
    begin : drive_proc
        bus_entry_t head;
        logic       start_next;
        logic       wen_next;
        if (rst_n)
        begin
            start_next = start && !word_taken;
            wen_next   = 1'b0;
            if (!start_next)
            begin
                if (hold_left != 0)
                    hold_left--;
                else if (pending.size() != 0)
                begin
                    if (pending[0].kind == ENTRY_SAMPLE || readings_due.size() == 0)
                    begin
                        head = pending.pop_front();
                        if (head.kind == ENTRY_SAMPLE)
                        begin
                            adc_sample <= head.sample;
                            start_next = 1'b1;
                            hold_left  = head.hold_off;
                        end
                        else
                        begin
                            cfg_index <= head.index;
                            cfg_data  <= head.data;
                            wen_next  = 1'b1;
                        end
                    end
                end
            end
            start   <= start_next;
            cfg_wen <= wen_next;
        end
    end

    // Monitor: check each result word, then predict for the word accepted now.
    always @(posedge clk)
    begin : watch_proc
        level_reading_t want;
        if (rst_n)
        begin
            word_taken <= start && !busy;
            if (done)
            begin
                if (readings_due.size() == 0)
                    report_mismatch($sformatf("result %h/%0d with nothing expected",
                                              scaled_value, light_level));
                else
                begin
                    want = readings_due.pop_front();
                    if (scaled_value !== want.value)
                        report_mismatch($sformatf("scaled_value %h, expected %h",
                                                  scaled_value, want.value));
                    if (light_level !== want.level)
                        report_mismatch($sformatf("light_level %0d, expected %0d",
                                                  light_level, want.level));
                end
            end
            if (start && !busy)
                readings_due.push_back(predict_reading(adc_sample));
            if (cfg_wen)
                apply_register_write(cfg_index, cfg_data);
        end
    end

    initial
    begin : stimulus_proc
        logic [THR_BITS-1:0] ladder;
        int                  gap_pct;
        ladder = {16'hFFFF, 16'd8000, 16'd7000, 16'd6000, 16'd5000,
                  16'd4000, 16'd3000, 16'd2000, 16'd1000, 16'd0};

        // Reset setting: unity gain, every threshold cleared.
        queue_sample(16'h0000, 0);
        queue_sample(16'h0001, 0);
        queue_sample(16'hFFFF, 0);

        // Calibration mode passes the raw sample; spare indexes must not disturb it.
        program_setting(1'b1, 16'd3, 16'd5, ladder);
        queue_write(CFG_SPARE_A, {$urandom, $urandom});
        queue_write(CFG_SPARE_B, {$urandom, $urandom});
        queue_sample(16'd0, 0);
        queue_sample(16'd1000, 0);
        queue_sample(16'd1001, 0);
        queue_sample(16'd8001, 0);
        queue_sample(16'hFFFF, 1);

        // Doubling gain, with saturation at the top.
        program_setting(1'b0, 16'd2, 16'd1, ladder);
        queue_sample(16'd500, 0);
        queue_sample(16'd40000, 2);
        queue_sample(16'h7FFF, 0);

        // Zero numerator, against set and then cleared thresholds.
        program_setting(1'b0, 16'd0, 16'd1, ladder);
        queue_sample(16'hFFFF, 0);
        program_setting(1'b0, 16'd0, 16'd7, '0);
        queue_sample(16'd1234, 0);

        // Zero divisor saturates, and no threshold is above the value.
        program_setting(1'b0, 16'hFFFF, 16'd0, {THRESHOLD_SLOTS{16'h1234}});
        queue_sample(16'h0000, 0);
        queue_sample(16'hFFFF, 3);

        // Gain extremes.
        program_setting(1'b0, 16'hFFFF, 16'hFFFF, ladder);
        queue_sample(16'hFFFF, 0);
        program_setting(1'b0, 16'd1, 16'hFFFF, ladder);
        queue_sample(16'hFFFF, 0);
        queue_sample(16'hFFFE, 0);
        program_setting(1'b0, 16'hFFFF, 16'd1, ladder);
        queue_sample(16'd2, 0);
        queue_sample(16'd1, 0);

        // Random settings, each followed by a run of aimed and random samples.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            program_setting($urandom_range(0, 3) == 0, pick_gain(), pick_gain(),
                            pick_thresholds());
            case ($urandom_range(0, 3))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                2:       gap_pct = 35;
                default: gap_pct = 70;
            endcase
            if (p >= RANDOM_PHASES - 2)
                gap_pct = 0;
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                queue_sample(pick_sample(),
                             ($urandom_range(1, 100) <= gap_pct) ? $urandom_range(1, 13) : 0);
        end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || start || readings_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (readings_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", readings_due.size()));

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : watchdog_proc
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
